>>> rtl/hsfd_pkg.sv
package hsfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_T_CRC   = 2'd1;
  localparam logic [1:0] STATUS_H_CRC   = 2'd2;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [1:0]         status;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;
    logic        temperature_ok;
    logic        humidity_ok;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_push_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/humidity_sensor_frame_decoder.sv
// Accepts one byte beat per cycle while the two-entry frame queue has room.
// The sixth byte of a frame is written into the queue at its accept edge; the frame is
// later scaled into the output register once that register is empty or being taken.
// Sustained throughput is one byte per cycle while out_ready stays high, one result per six bytes.
// Synchronous active-low reset empties the queue and output and restarts at byte 0.
module humidity_sensor_frame_decoder import hsfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  frame_push_t push;
  logic        full;
  logic        head_valid;
  frame_t      head;
  logic        pop;

  assign in_ready = !full;

  hsfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push)
  );

  hsfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  hsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> rtl/hsfd_front.sv
module hsfd_front import hsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_beat_t    in_data,
  output frame_push_t push
);

  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] raw_t_r, raw_t_nxt;
  logic [7:0]  hum_hi_r, hum_hi_nxt;
  logic [7:0]  hum_lo_r, hum_lo_nxt;
  logic        t_ok_r, t_ok_nxt;
  logic [2:0]  pos;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    pos = in_data.frame_start ? POS_T_HI : byte_pos_r;
    if (pos > POS_H_CRC) begin
      pos = POS_T_HI;
    end
  end

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    crc_nxt      = crc_r;
    raw_t_nxt    = raw_t_r;
    hum_hi_nxt   = hum_hi_r;
    hum_lo_nxt   = hum_lo_r;
    t_ok_nxt     = t_ok_r;
    push.valid   = 1'b0;
    push.frame.raw_temperature = raw_t_r;
    push.frame.raw_humidity    = {hum_hi_r, hum_lo_r};
    push.frame.temperature_ok  = t_ok_r;
    push.frame.humidity_ok     = (crc_r == in_data.data_byte);
    if (accept) begin
      byte_pos_nxt = (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
      case (pos)
        POS_T_HI: begin
          crc_nxt   = crc_byte(CRC_INIT, in_data.data_byte);
          raw_t_nxt = {in_data.data_byte, 8'd0};
        end
        POS_T_LO: begin
          crc_nxt   = crc_byte(crc_r, in_data.data_byte);
          raw_t_nxt = {raw_t_r[15:8], in_data.data_byte};
        end
        POS_T_CRC: begin
          t_ok_nxt = (crc_r == in_data.data_byte);
          crc_nxt  = CRC_INIT;
        end
        POS_H_HI: begin
          crc_nxt    = crc_byte(CRC_INIT, in_data.data_byte);
          hum_hi_nxt = in_data.data_byte;
        end
        POS_H_LO: begin
          crc_nxt    = crc_byte(crc_r, in_data.data_byte);
          hum_lo_nxt = in_data.data_byte;
        end
        default: begin
          push.valid = 1'b1;
          crc_nxt    = CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= POS_T_HI;
      crc_r      <= CRC_INIT;
      raw_t_r    <= '0;
      hum_hi_r   <= '0;
      hum_lo_r   <= '0;
      t_ok_r     <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      crc_r      <= crc_nxt;
      raw_t_r    <= raw_t_nxt;
      hum_hi_r   <= hum_hi_nxt;
      hum_lo_r   <= hum_lo_nxt;
      t_ok_r     <= t_ok_nxt;
    end
  end

endmodule

>>> rtl/hsfd_queue.sv
module hsfd_queue import hsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_push_t push,
  output logic        full,
  output logic        head_valid,
  output frame_t      head,
  input  logic        pop
);

  frame_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/hsfd_back.sv
module hsfd_back import hsfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  frame_t    head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r, out_data_nxt;
  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic signed [15:0] temp_val;

  assign pop       = head_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign temp_prod = {15'd0, head.raw_temperature} * {16'd0, TEMP_SCALE};
  assign hum_prod  = {14'd0, head.raw_humidity} * {16'd0, HUM_SCALE};
  assign temp_val  = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (!head.temperature_ok) begin
        out_data_nxt = '{temperature_centi: '0, humidity_centi: '0, status: STATUS_T_CRC};
      end else if (!head.humidity_ok) begin
        out_data_nxt = '{temperature_centi: '0, humidity_centi: '0, status: STATUS_H_CRC};
      end else begin
        out_data_nxt.temperature_centi = temp_val[14:0];
        out_data_nxt.humidity_centi    = hum_prod[29:16];
        out_data_nxt.status            = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/hsfd_checker.sv
module hsfd_checker import hsfd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Reset did not empty the block.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |->
      out_data.temperature_centi == 15'sd0 && out_data.humidity_centi == 14'd0)
    else $error("Error result carries nonzero values.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == STATUS_OK || out_data.status == STATUS_T_CRC ||
      out_data.status == STATUS_H_CRC)
    else $error("Unknown status code.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_OK |->
      out_data.humidity_centi <= 14'd9999 && out_data.temperature_centi >= -15'sd4500)
    else $error("Scaled value out of range.");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);
